// File: design/ultrasonic_uart_range_poller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic range poller
// Clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_UART_RANGE_POLLER_CORE_ASSERT_SVH
`define ULTRASONIC_UART_RANGE_POLLER_CORE_ASSERT_SVH

// Same-cycle implication
`define URRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define URRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/urrp_pkg.sv
// ----------------------------------------------------------------------------
// urrp_pkg
// Types and constants of the ultrasonic range poller.
// ----------------------------------------------------------------------------
`default_nettype none

package urrp_pkg;

    // Default receive FIFO depth
    localparam int FIFO_DEPTH_DEF = 64;

    // Item request codes
    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_RX_BYTE   = 2'd1,
        REQ_MODE_DIST = 2'd2,
        REQ_MODE_TEMP = 2'd3
    } t_req;

    // Configuration register select (paddr bit 2)
    localparam logic REG_MIN_DISTANCE = 1'b0;
    localparam logic REG_MAX_DISTANCE = 1'b1;

    // Sensor query commands
    localparam logic [6:0] CMD_DISTANCE    = 7'h55;
    localparam logic [6:0] CMD_TEMPERATURE = 7'h50;

    // Temperature offset of the raw byte
    localparam logic [8:0] TEMP_OFFSET = 9'd45;

endpackage

`default_nettype wire

// File: design/ultrasonic_uart_range_poller_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_uart_range_poller_core
// Buffers sensor bytes in a receive FIFO and, on each timer tick, decodes a
// distance or temperature reading and issues the next query command.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------
//  item in  | input     | i_valid / o_stall    | i_req_type, i_rx_byte
//  result   | output    | o_valid / i_stall    | o_tx_command, o_distance_mm,
//           |           |                      | o_temperature_c
//  config   | input     | APB psel/penable     | paddr, pwdata, prdata
//
//  One item is taken per cycle while o_stall is low. A timer tick gives its
//  result through the registered FIFO read stage and then the decode into the
//  result register. Other items give no result and update state at once.
//  i_stall holds the result register and, once the read stage is also full,
//  raises o_stall. Synchronous active-low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_uart_range_poller_core #(
    parameter int FIFO_DEPTH = urrp_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item input
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [7:0]         i_rx_byte,
    // result output
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [6:0]              o_tx_command,
    output logic [15:0]             o_distance_mm,
    output logic signed [8:0]       o_temperature_c,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    import urrp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Advance a FIFO pointer with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Registers
    logic [15:0]      r_min_dist, r_max_dist;
    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;
    logic             r_temp_mode, r_flush;
    logic             r_s1_valid, r_s1_pop_dist, r_s1_pop_temp, r_s1_temp_mode;
    logic [7:0]       r_rd_hi, r_rd_lo;
    logic             r_out_valid;
    logic [6:0]       r_out_cmd;
    logic [15:0]      r_last_dist;
    logic [8:0]       r_last_temp;

    // Next values
    logic [PTR_W-1:0] n_head, n_tail;
    logic [CNT_W-1:0] n_count;
    logic             n_temp_mode, n_flush;
    logic             n_pop_dist, n_pop_temp;

    logic             out_free, s1_move, accept, is_tick, wr_en, cfg_wr;
    logic [CNT_W-1:0] eff_count;
    logic [PTR_W-1:0] head_p1;
    logic [15:0]      rd_dist;
    logic             in_range;
    t_req             req;

    // Handshake
    assign req      = t_req'(i_req_type);
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;
    assign is_tick  = (req == REQ_TICK);
    assign head_p1  = ptr_inc(r_head);
    assign wr_en    = accept && (req == REQ_RX_BYTE) && (r_count != CNT_FULL);

    // Work out FIFO and mode state for the accepted item
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_temp_mode = r_temp_mode;
        n_flush     = r_flush;
        n_pop_dist  = 1'b0;
        n_pop_temp  = 1'b0;
        eff_count   = r_flush ? '0 : r_count;
        unique case (req)
            REQ_RX_BYTE: begin
                if (r_count != CNT_FULL) begin
                    n_tail  = ptr_inc(r_tail);
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_MODE_DIST, REQ_MODE_TEMP: begin
                n_temp_mode = (req == REQ_MODE_TEMP);
                n_flush     = 1'b1;
            end
            default: begin
                // timer tick: drop a pending flush, then pop
                n_flush = 1'b0;
                if (r_flush) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                if (!r_temp_mode && eff_count >= CNT_W'(2)) begin
                    n_pop_dist = 1'b1;
                    n_head     = ptr_inc(head_p1);
                    n_count    = eff_count - CNT_W'(2);
                end else if (r_temp_mode && eff_count >= CNT_W'(1)) begin
                    n_pop_temp = 1'b1;
                    n_head     = head_p1;
                    n_count    = eff_count - CNT_W'(1);
                end
            end
        endcase
    end

    // FIFO storage: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_rx_byte;
        end
        if (accept && is_tick) begin
            r_rd_hi <= r_mem[r_head];
            r_rd_lo <= r_mem[head_p1];
        end
    end

    // Hold FIFO pointers, mode and read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_temp_mode   <= 1'b0;
            r_flush       <= 1'b0;
            r_s1_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_temp_mode <= n_temp_mode;
                r_flush     <= n_flush;
                r_s1_valid  <= is_tick;
            end else if (s1_move) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_tick) begin
            r_s1_pop_dist  <= n_pop_dist;
            r_s1_pop_temp  <= n_pop_temp;
            r_s1_temp_mode <= r_temp_mode;
        end
    end

    // Decode the popped bytes
    assign rd_dist  = {r_rd_hi, r_rd_lo};
    assign in_range = (rd_dist >= r_min_dist) && (rd_dist <= r_max_dist);

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_dist <= '0;
            r_last_temp <= '0;
        end else begin
            if (s1_move) begin
                r_out_valid <= 1'b1;
                if (r_s1_pop_dist) begin
                    r_last_dist <= in_range ? rd_dist : 16'd0;
                end
                if (r_s1_pop_temp) begin
                    r_last_temp <= {1'b0, r_rd_hi} - TEMP_OFFSET;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_cmd <= r_s1_temp_mode ? CMD_TEMPERATURE : CMD_DISTANCE;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_command    = r_out_cmd;
    assign o_distance_mm   = r_last_dist;
    assign o_temperature_c = signed'(r_last_temp);

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= 16'd0;
            r_max_dist <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_DISTANCE: r_min_dist <= pwdata[15:0];
                default:          r_max_dist <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_DISTANCE: prdata = {16'd0, r_max_dist};
            default:          prdata = {16'd0, r_min_dist};
        endcase
    end

    // Checks
    `include "ultrasonic_uart_range_poller_core_assert.svh"

    `URRP_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_FULL, "FIFO count beyond depth")
    `URRP_ASSERT_NOW(a_ptr_match, (r_count == '0) || (r_count == CNT_FULL), r_head == r_tail, "FIFO pointers disagree with count")
    `URRP_ASSERT_NEXT(a_no_result, accept && !is_tick, !r_s1_valid, "result staged without a tick")
    `URRP_ASSERT_NEXT(a_flush_done, accept && is_tick, !r_flush, "flush still pending after tick")

endmodule

`default_nettype wire
